@@ rtl/heap_canary_table_macros.svh @@
// ----------------------------------------------------------------------------
// Heap canary table assertion macros
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HEAP_CANARY_TABLE_MACROS_SVH
`define HEAP_CANARY_TABLE_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock outside reset
`define HCT_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("heap canary table: assertion failed");
// expression must never be true outside reset
`define HCT_NEVER(lbl, ck, rstn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) !(expr)) \
		else $error("heap canary table: forbidden condition seen");
`else
`define HCT_ASSERT(lbl, ck, rstn, prop)
`define HCT_NEVER(lbl, ck, rstn, expr)
`endif

`endif

@@ rtl/hct_pkg.sv @@
// ----------------------------------------------------------------------------
// Heap canary table package
// Command and status codes, word layouts and shared structs.
// ----------------------------------------------------------------------------
package hct_pkg;

	// commands (input tuser)
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_CHECK  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_MISMATCH  = 3'd3;
	localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

	localparam int CMD_W        = 2;
	localparam int GADDR_W      = 32;
	localparam int CANARY_W     = 16;
	localparam int PROBE_W      = 6;
	localparam int OBS_W        = 64;
	localparam int STATUS_W     = 3;
	localparam int SLOT_W       = 6;
	localparam int COUNT_OUT_W  = 7;
	localparam int S_TDATA_W    = 120;
	localparam int M_TDATA_W    = 72;

	// canary value of a slot after the clearing pass
	localparam logic [CANARY_W-1:0] CANARY_CLEAR = 16'hFFFF;

	// compare unit verdict on one slot word
	typedef struct packed {
		logic is_free;
		logic addr_hit;
		logic canary_eq;
	} match_t;

	// one result word
	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [SLOT_W-1:0]      slot_index;
		logic                   mem_write_valid;
		logic [GADDR_W-1:0]     mem_write_address;
		logic [CANARY_W-1:0]    mem_write_value;
		logic [COUNT_OUT_W-1:0] active_count;
	} result_t;

endpackage

@@ rtl/hct_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hct_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/hct_match.sv @@
// ----------------------------------------------------------------------------
// Heap canary table slot compare unit
// Judges one slot word: free, address hit, canary equal to observed word.
// ----------------------------------------------------------------------------
module hct_match #(
	parameter int AW = 32
) (
	input  logic [AW+hct_pkg::CANARY_W-1:0] slot_word,
	input  logic [AW-1:0]                   key_addr,
	input  logic [hct_pkg::OBS_W-1:0]       observed,
	output hct_pkg::match_t                 verdict
);

	logic [AW-1:0]                slot_addr;
	logic [hct_pkg::CANARY_W-1:0] slot_canary;

	assign slot_addr   = slot_word[AW-1:0];
	assign slot_canary = slot_word[AW+hct_pkg::CANARY_W-1:AW];

	always_comb begin
		verdict.is_free   = (slot_addr == '0);
		verdict.addr_hit  = (slot_addr == key_addr);
		verdict.canary_eq = (hct_pkg::OBS_W'(slot_canary) == observed);
	end

endmodule

@@ rtl/hct_ctrl.sv @@
// ----------------------------------------------------------------------------
// Heap canary table sequencer
// Clearing pass, probe start reduction, one-slot-per-cycle scan, table update.
// ----------------------------------------------------------------------------
`include "heap_canary_table_macros.svh"

module hct_ctrl #(
	parameter int ENTRIES = 64,
	parameter int AW      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hct_pkg::CMD_W-1:0]       cmd,
	input  logic [AW-1:0]                   key_addr,
	input  logic [hct_pkg::CANARY_W-1:0]    canary,
	input  logic [hct_pkg::PROBE_W-1:0]     probe_start,
	input  logic [hct_pkg::OBS_W-1:0]       observed,
	// table memory
	output logic                            ram_we,
	output logic [$clog2(ENTRIES)-1:0]      ram_waddr,
	output logic [AW+hct_pkg::CANARY_W-1:0] ram_wdata,
	output logic [$clog2(ENTRIES)-1:0]      ram_raddr,
	input  logic [AW+hct_pkg::CANARY_W-1:0] ram_rdata,
	// compare unit
	output logic [AW-1:0]                   cmp_key,
	output logic [hct_pkg::OBS_W-1:0]       cmp_observed,
	input  hct_pkg::match_t                 verdict,
	// result side
	output logic                            res_valid,
	input  logic                            res_ready,
	output hct_pkg::result_t                res
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int WW = (CW > hct_pkg::PROBE_W) ? CW : hct_pkg::PROBE_W;
	localparam int DW = AW + hct_pkg::CANARY_W;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_REDUCE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]                   state_q;
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                pidx_q;
	logic                         pend_q;
	logic [CW-1:0]                steps_q;
	logic [CW-1:0]                cnt_q;
	logic [hct_pkg::CMD_W-1:0]    cmd_q;
	logic [AW-1:0]                key_q;
	logic [hct_pkg::CANARY_W-1:0] canary_q;
	logic [hct_pkg::OBS_W-1:0]    obs_q;
	logic [WW-1:0]                start_q;
	hct_pkg::result_t             res_q;

	logic             idx_last;
	logic [IW-1:0]    idx_inc;
	logic             hit;
	logic             found;
	logic             exhausted;
	logic             start_big;
	logic [CW-1:0]    cnt_d;
	hct_pkg::result_t res_idle;
	hct_pkg::result_t res_scan;

	assign idx_last  = (idx_q == IW'(ENTRIES - 1));
	assign idx_inc   = idx_last ? '0 : idx_q + 1'b1;
	assign hit       = (cmd_q == hct_pkg::CMD_ADD) ? verdict.is_free : verdict.addr_hit;
	assign found     = (state_q == S_SCAN) && pend_q && hit;
	assign exhausted = (state_q == S_SCAN) && !pend_q && (steps_q == CW'(ENTRIES));
	assign start_big = (start_q >= WW'(ENTRIES));

	assign in_ready     = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_DONE);
	assign res          = res_q;
	assign cmp_key      = key_q;
	assign cmp_observed = obs_q;

	// memory port: clearing sweep, or the single update after a hit
	always_comb begin
		ram_raddr = idx_q;
		ram_we    = (state_q == S_CLEAR) || (found && (cmd_q != hct_pkg::CMD_CHECK));
		ram_waddr = (state_q == S_CLEAR) ? idx_q : pidx_q;
		if (state_q == S_CLEAR) begin
			ram_wdata = {hct_pkg::CANARY_CLEAR, {AW{1'b0}}};
		end else if (cmd_q == hct_pkg::CMD_ADD) begin
			ram_wdata = {canary_q, key_q};
		end else begin
			// freed slot keeps its canary
			ram_wdata = {ram_rdata[DW-1:AW], {AW{1'b0}}};
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (found && (cmd_q == hct_pkg::CMD_ADD)) begin
			cnt_d = cnt_q + 1'b1;
		end else if (found && (cmd_q == hct_pkg::CMD_REMOVE) && (cnt_q != '0)) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	// result for items settled without a scan
	always_comb begin
		res_idle = '0;
		res_idle.status = (cmd != hct_pkg::CMD_NONE) ? hct_pkg::ST_BAD_ADDR : hct_pkg::ST_OK;
		res_idle.active_count = hct_pkg::COUNT_OUT_W'(cnt_q);
	end

	always_comb begin
		res_scan = '0;
		if (found) begin
			res_scan.slot_index = hct_pkg::SLOT_W'(pidx_q);
			unique case (cmd_q)
				hct_pkg::CMD_ADD: begin
					res_scan.status            = hct_pkg::ST_OK;
					res_scan.mem_write_valid   = 1'b1;
					res_scan.mem_write_address = hct_pkg::GADDR_W'(key_q);
					res_scan.mem_write_value   = canary_q;
				end
				hct_pkg::CMD_CHECK: begin
					res_scan.status = verdict.canary_eq ? hct_pkg::ST_OK : hct_pkg::ST_MISMATCH;
				end
				default: begin
					res_scan.status = hct_pkg::ST_OK;
				end
			endcase
		end else begin
			res_scan.status = (cmd_q == hct_pkg::CMD_ADD) ? hct_pkg::ST_FULL
				: hct_pkg::ST_NOT_FOUND;
		end
		res_scan.active_count = hct_pkg::COUNT_OUT_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			pidx_q  <= '0;
			pend_q  <= 1'b0;
			steps_q <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_inc;
					if (idx_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						priority if (cmd == hct_pkg::CMD_NONE || key_addr == '0) begin
							state_q <= S_DONE;
						end else if (cmd == hct_pkg::CMD_ADD) begin
							state_q <= S_REDUCE;
						end else begin
							state_q <= S_SCAN;
							idx_q   <= '0;
							steps_q <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				S_REDUCE: begin
					if (!start_big) begin
						state_q <= S_SCAN;
						idx_q   <= start_q[IW-1:0];
						steps_q <= '0;
						pend_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (found || exhausted) begin
						state_q <= S_DONE;
						cnt_q   <= cnt_d;
						pend_q  <= 1'b0;
					end else if (steps_q != CW'(ENTRIES)) begin
						pend_q  <= 1'b1;
						pidx_q  <= idx_q;
						idx_q   <= idx_inc;
						steps_q <= steps_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q    <= cmd;
			key_q    <= key_addr;
			canary_q <= canary;
			obs_q    <= observed;
			start_q  <= WW'(probe_start);
			res_q    <= res_idle;
		end
		if (state_q == S_REDUCE && start_big) begin
			start_q <= start_q - WW'(ENTRIES);
		end
		if (found || exhausted) begin
			res_q <= res_scan;
		end
	end

	`HCT_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CW'(ENTRIES))
	`HCT_ASSERT(a_scan_bound, clk, arst_n, steps_q <= CW'(ENTRIES))
	`HCT_ASSERT(a_add_has_room, clk, arst_n, (found && cmd_q == hct_pkg::CMD_ADD) |-> (cnt_q < CW'(ENTRIES)))
	`HCT_NEVER(a_no_idle_write, clk, arst_n, ram_we && (state_q == S_IDLE || state_q == S_DONE))

endmodule

@@ rtl/heap_canary_table.sv @@
// ----------------------------------------------------------------------------
// Heap canary table
// Keeps ENTRIES pairs of guarded heap address and 16-bit canary in one RAM;
// address zero marks a free slot. An add probes from probe_start (taken modulo
// ENTRIES), wrapping, for the first free slot, stores the pair and returns a
// memory write of the canary; a remove frees the lowest slot holding the
// address; a check compares the observed 64-bit word with the stored canary.
// Each input word yields exactly one result word. After reset the block runs a
// clearing pass over every slot with tready low. A remove or check scans from
// slot zero and stops at the match; an absent address reads every slot. An
// add first reduces probe_start below ENTRIES, then scans; a full table is
// read in full. A scan is paced by the table RAM's single read port, which
// yields one slot a cycle to the shared compare unit. A zero address or an
// unused command is answered without a scan. A finished result sits in the
// output register, so the next word is taken while it waits for
// m_axis_tready; only a second finished result waits on it.
// ----------------------------------------------------------------------------
module heap_canary_table #(
	parameter int ENTRIES    = 64,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input words
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// guarded_address[31:0], canary_value[47:32], probe_start[53:48],
	// observed_value[117:54], zero pad [119:118]
	input  logic [hct_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [hct_pkg::CMD_W-1:0]     s_axis_tuser,
	// result words
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status[2:0], slot_index[8:3], mem_write_valid[9],
	// mem_write_address[41:10], mem_write_value[57:42], active_count[64:58],
	// zero pad [71:65]
	output logic [hct_pkg::M_TDATA_W-1:0] m_axis_tdata
);

	// stored address width: the field carries 32 bits
	localparam int AW = (ADDR_WIDTH < hct_pkg::GADDR_W) ? ADDR_WIDTH : hct_pkg::GADDR_W;
	localparam int IW = $clog2(ENTRIES);
	localparam int DW = AW + hct_pkg::CANARY_W;

	// unpacked input word
	logic [AW-1:0]                   in_addr;
	logic [hct_pkg::CANARY_W-1:0]    in_canary;
	logic [hct_pkg::PROBE_W-1:0]     in_probe;
	logic [hct_pkg::OBS_W-1:0]       in_observed;

	assign in_addr     = s_axis_tdata[AW-1:0];
	assign in_canary   = s_axis_tdata[47:32];
	assign in_probe    = s_axis_tdata[53:48];
	assign in_observed = s_axis_tdata[117:54];

	// table memory and compare unit wiring
	logic                         ram_we;
	logic [IW-1:0]                ram_waddr;
	logic [DW-1:0]                ram_wdata;
	logic [IW-1:0]                ram_raddr;
	logic [DW-1:0]                ram_rdata;
	logic [AW-1:0]                cmp_key;
	logic [hct_pkg::OBS_W-1:0]    cmp_observed;
	hct_pkg::match_t              verdict;

	logic                         res_valid;
	logic                         res_ready;
	hct_pkg::result_t             res;

	// output register
	logic                         m_valid_q;
	hct_pkg::result_t             m_res_q;

	hct_ram #(
		.WIDTH (DW),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	hct_match #(
		.AW (AW)
	) u_match (
		.slot_word (ram_rdata),
		.key_addr  (cmp_key),
		.observed  (cmp_observed),
		.verdict   (verdict)
	);

	hct_ctrl #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.cmd          (s_axis_tuser),
		.key_addr     (in_addr),
		.canary       (in_canary),
		.probe_start  (in_probe),
		.observed     (in_observed),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.cmp_key      (cmp_key),
		.cmp_observed (cmp_observed),
		.verdict      (verdict),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// take the sequencer's result whenever the output register is free or
	// being emptied this cycle
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0,
		m_res_q.active_count,
		m_res_q.mem_write_value,
		m_res_q.mem_write_address,
		m_res_q.mem_write_valid,
		m_res_q.slot_index,
		m_res_q.status};

endmodule
